// ===== sv/i2cm_pkg.sv =====
// Package: shared types and constants of the I2C register access master.
`timescale 1ns / 1ps
package i2cm_pkg;

  // Command codes carried by each input item
  localparam logic [1:0] CMD_IDLE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD    = 1'd1;

  // Register reset values
  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd118;
  localparam logic [7:0] HALF_PERIOD_RESET    = 8'd5;

  // Sequencer phases of the bus waveform
  typedef enum logic [3:0] {
    PH_IDLE, PH_S1, PH_S2, PH_S3,
    PH_W1, PH_W2, PH_W3, PH_W4,
    PH_R1, PH_R2, PH_R3, PH_R4,
    PH_P1, PH_P2
  } phase_t;

  // One result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
  } result_t;

endpackage

// ===== sv/i2cm_if.sv =====
// Interfaces: command and result channels of the I2C register access master.
`timescale 1ns / 1ps
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] register_address;
  logic [7:0] write_value;
  logic       sda_in;

  modport source (output valid, command, register_address, write_value, sda_in,
                  input ready);
  modport sink (input valid, command, register_address, write_value, sda_in,
                output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_value;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_value, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                read_value, output ready);
endinterface

// ===== sv/i2c_register_access_master.sv =====
// Top level: I2C register access master with config registers and output stage.
`timescale 1ns / 1ps
// Each accepted item is one tick of bus time. The block takes one item in every
// cycle it is ready and delivers exactly one result item for it from an output
// register in the next cycle, computed in one pass through the phase sequencer's
// next-state logic. The input side stays ready while the output register is empty
// or being taken, so a stall on the result side holds off new items only while a
// result waits. Write and read transactions are launched by the command field of
// an item while idle; register device_address (index 0) and half_period_ticks
// (index 1) are written through the cfg_write/cfg_index/cfg_data port.
module i2c_register_access_master (
  input  logic                          clk,
  input  logic                          rst,
  i2cm_cmd_if.sink                      req,
  i2cm_res_if.source                    rsp,
  input  logic                          cfg_write,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import i2cm_pkg::*;

  logic [6:0] device_address;
  logic [7:0] half_period_ticks;
  logic       step;
  result_t    result;
  logic       out_valid;
  result_t    out_item;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= DEVICE_ADDRESS_RESET;
      half_period_ticks <= HALF_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS: device_address    <= cfg_data[6:0];
        REG_HALF_PERIOD:    half_period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept an item while the output register is free or draining
  assign req.ready = !out_valid || rsp.ready;
  assign step      = req.valid && req.ready;

  i2cm_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .command           (req.command),
    .register_address  (req.register_address),
    .write_value       (req.write_value),
    .sda_in            (req.sda_in),
    .device_address    (device_address),
    .half_period_ticks (half_period_ticks),
    .result            (result)
  );

  // Hold the result item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.scl_level  = out_item.scl_level;
  assign rsp.sda_level  = out_item.sda_level;
  assign rsp.sda_drive  = out_item.sda_drive;
  assign rsp.busy_res   = out_item.busy_res;
  assign rsp.done_res   = out_item.done_res;
  assign rsp.read_value = out_item.read_value;

endmodule

// ===== sv/i2cm_seq.sv =====
// Sequencer: bus phase state machine that advances one tick per accepted item.
`timescale 1ns / 1ps
module i2cm_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [1:0]    command,
  input  logic [7:0]    register_address,
  input  logic [7:0]    write_value,
  input  logic          sda_in,
  input  logic [6:0]    device_address,
  input  logic [7:0]    half_period_ticks,
  output i2cm_pkg::result_t result
);
  import i2cm_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] delay_count, delay_count_next;
  logic [7:0] saved_register, saved_register_next;
  logic [7:0] saved_value, saved_value_next;
  logic [7:0] received_byte, received_byte_next;
  logic       is_read, is_read_next;
  logic [2:0] byte_index, byte_index_next;
  logic       scl, scl_next;
  logic       sda, sda_next;
  logic       drive, drive_next;
  logic       done;
  logic       is_delay;
  logic [7:0] phase_len;
  logic [7:0] dc_inc;
  logic [7:0] addr_byte;

  assign addr_byte = {device_address, 1'b0};

  // Hold state between items, advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= '0;
      shift_byte     <= '0;
      delay_count    <= '0;
      saved_register <= '0;
      saved_value    <= '0;
      received_byte  <= '0;
      is_read        <= 1'b0;
      byte_index     <= '0;
      scl            <= 1'b1;
      sda            <= 1'b1;
      drive          <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      delay_count    <= delay_count_next;
      saved_register <= saved_register_next;
      saved_value    <= saved_value_next;
      received_byte  <= received_byte_next;
      is_read        <= is_read_next;
      byte_index     <= byte_index_next;
      scl            <= scl_next;
      sda            <= sda_next;
      drive          <= drive_next;
    end
  end

  // Next state and line levels for one tick
  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    delay_count_next    = delay_count;
    saved_register_next = saved_register;
    saved_value_next    = saved_value;
    received_byte_next  = received_byte;
    is_read_next        = is_read;
    byte_index_next     = byte_index;
    scl_next            = scl;
    sda_next            = sda;
    drive_next          = drive;
    done                = 1'b0;
    is_delay            = 1'b0;
    phase_len           = 8'd1;
    dc_inc              = '0;

    // Launch a transaction from idle
    if (phase == PH_IDLE && (command == CMD_WRITE || command == CMD_READ)) begin
      saved_register_next = register_address;
      saved_value_next    = write_value;
      is_read_next        = (command == CMD_READ);
      byte_index_next     = '0;
      bit_count_next      = '0;
      delay_count_next    = '0;
      phase_next          = PH_S1;
    end

    if (phase_next != PH_IDLE) begin
      is_delay = (phase_next == PH_S1) || (phase_next == PH_S2) ||
                 (phase_next == PH_W1) || (phase_next == PH_W2) ||
                 (phase_next == PH_W3) || (phase_next == PH_R1) ||
                 (phase_next == PH_R2) || (phase_next == PH_R3) ||
                 (phase_next == PH_P1);
      phase_len = (is_delay && half_period_ticks != 8'd0) ? half_period_ticks : 8'd1;

      // Drive the lines for the current phase
      unique case (phase_next)
        PH_S1: begin drive_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1; end
        PH_S2: sda_next = 1'b0;
        PH_S3: scl_next = 1'b0;
        PH_W1: begin sda_next = shift_byte_next[7]; scl_next = 1'b1; end
        PH_W2: scl_next = 1'b0;
        PH_W3: begin drive_next = 1'b0; scl_next = 1'b1; end
        PH_W4: begin scl_next = 1'b0; drive_next = 1'b1; end
        PH_R1: begin drive_next = 1'b0; scl_next = 1'b1; end
        PH_R2: scl_next = 1'b0;
        PH_R3: begin drive_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1; end
        PH_R4: scl_next = 1'b0;
        PH_P1: begin sda_next = 1'b0; scl_next = 1'b1; end
        PH_P2: sda_next = 1'b1;
        default: ;
      endcase

      // Count the tick and close the phase when its length is reached
      dc_inc = delay_count_next + 8'd1;
      if (dc_inc >= phase_len || dc_inc == 8'd0) begin
        delay_count_next = '0;
        unique case (phase_next)
          PH_S1: phase_next = PH_S2;
          PH_S2: phase_next = PH_S3;
          PH_W1: phase_next = PH_W2;
          PH_W2: begin
            shift_byte_next = {shift_byte_next[6:0], 1'b0};
            bit_count_next  = bit_count_next + 4'd1;
            if (bit_count_next >= 4'd8) begin
              bit_count_next = '0;
              phase_next     = PH_W3;
            end else begin
              phase_next = PH_W1;
            end
          end
          PH_W3: phase_next = PH_W4;
          PH_R1: begin
            shift_byte_next = {shift_byte_next[6:0], sda_in};
            phase_next      = PH_R2;
          end
          PH_R2: begin
            bit_count_next = bit_count_next + 4'd1;
            if (bit_count_next >= 4'd8) begin
              bit_count_next     = '0;
              received_byte_next = shift_byte_next;
              phase_next         = PH_R3;
            end else begin
              phase_next = PH_R1;
            end
          end
          PH_R3: phase_next = PH_R4;
          PH_P1: phase_next = PH_P2;
          PH_P2: begin
            phase_next      = PH_IDLE;
            byte_index_next = '0;
            done            = 1'b1;
          end
          PH_S3, PH_W4, PH_R4: begin
            // Move on to the next byte of the transaction
            byte_index_next = byte_index_next + 3'd1;
            case (byte_index_next)
              3'd0: phase_next = PH_S1;
              3'd1: begin
                phase_next = PH_W1; bit_count_next = '0; shift_byte_next = addr_byte;
              end
              3'd2: begin
                phase_next = PH_W1; bit_count_next = '0;
                shift_byte_next = saved_register_next;
              end
              default: begin
                if (!is_read_next) begin
                  if (byte_index_next == 3'd3) begin
                    phase_next = PH_W1; bit_count_next = '0;
                    shift_byte_next = saved_value_next;
                  end else begin
                    phase_next = PH_P1;
                  end
                end else if (byte_index_next == 3'd3) begin
                  phase_next = PH_S1;
                end else if (byte_index_next == 3'd4) begin
                  phase_next = PH_W1; bit_count_next = '0;
                  shift_byte_next = addr_byte | 8'd1;
                end else if (byte_index_next == 3'd5) begin
                  phase_next = PH_R1; bit_count_next = '0; shift_byte_next = '0;
                end else begin
                  phase_next = PH_P1;
                end
              end
            endcase
          end
          default: phase_next = PH_IDLE;
        endcase
      end else begin
        delay_count_next = dc_inc;
      end
    end
  end

  // Result of this tick
  assign result.scl_level  = scl_next;
  assign result.sda_level  = sda_next;
  assign result.sda_drive  = drive_next;
  assign result.busy_res   = (phase_next != PH_IDLE);
  assign result.done_res   = done;
  assign result.read_value = received_byte_next;

endmodule

// ===== sv/i2cm_checker.sv =====
// Checker: port-level assertions on the I2C register access master, with bind.
`timescale 1ns / 1ps
module i2cm_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       scl_level,
  input logic       sda_level,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_value
);

  // Stalled result item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(done_res))
    else $error("stalled result item changed");

  // Every accepted item yields a result in the next cycle
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted item produced no result");

  // Empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input blocked with empty output stage");

  // Completion ends the transaction with a stop condition
  a_done_stop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && done_res |-> !busy_res && scl_level && sda_level)
    else $error("completion without stop condition or while busy");

endmodule

bind i2c_register_access_master i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .scl_level  (rsp.scl_level),
  .sda_level  (rsp.sda_level),
  .busy_res   (rsp.busy_res),
  .done_res   (rsp.done_res),
  .read_value (rsp.read_value)
);

// ===== dv/tb_i2c_register_access_master.sv =====
// Testbench: directed and random bus ticks checked against a cycle-level model of the master.
`timescale 1ns / 1ps
module tb_i2c_register_access_master;
  import i2cm_pkg::*;

  // Spare command code, treated as an idle tick
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // How sda_in is driven during a transfer
  localparam int SDA_RAND = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_LOW  = 2;

  // Tracks the bus sequencer tick by tick and holds the line levels still owed
  class bus_level_board;
    phase_t     ph;
    logic [3:0] bits_done;
    logic [7:0] shifter;
    logic [7:0] dly;
    logic [7:0] keep_reg;
    logic [7:0] keep_val;
    logic [7:0] rx_byte;
    logic [7:0] half_ticks;
    logic [6:0] dev_addr;
    logic [2:0] step_idx;
    logic       rd;
    logic       scl_q;
    logic       sda_q;
    logic       drv_q;
    result_t    pending_levels[$];
    int         errors;

    function new();
      ph = PH_IDLE;
      bits_done = '0;
      shifter = '0;
      dly = '0;
      keep_reg = '0;
      keep_val = '0;
      rx_byte = '0;
      rd = 1'b0;
      step_idx = '0;
      dev_addr = DEVICE_ADDRESS_RESET;
      half_ticks = HALF_PERIOD_RESET;
      scl_q = 1'b1;
      sda_q = 1'b1;
      drv_q = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      if (idx == REG_DEVICE_ADDRESS) dev_addr = data[6:0];
      else if (idx == REG_HALF_PERIOD) half_ticks = data;
    endfunction

    function void load_out(logic [7:0] v);
      ph = PH_W1;
      bits_done = '0;
      shifter = v;
    endfunction

    // Pick the phase that opens the current byte slot of the transaction
    function void open_step();
      if (step_idx == 3'd0) ph = PH_S1;
      else if (step_idx == 3'd1) load_out({dev_addr, 1'b0});
      else if (step_idx == 3'd2) load_out(keep_reg);
      else if (!rd) begin
        if (step_idx == 3'd3) load_out(keep_val);
        else ph = PH_P1;
      end else if (step_idx == 3'd3) ph = PH_S1;
      else if (step_idx == 3'd4) load_out({dev_addr, 1'b1});
      else if (step_idx == 3'd5) begin
        ph = PH_R1;
        bits_done = '0;
        shifter = '0;
      end else ph = PH_P1;
    endfunction

    // Advance past the phase that just ran out; 1 when the stop completes
    function bit close_phase(logic sda);
      case (ph)
        PH_S1: ph = PH_S2;
        PH_S2: ph = PH_S3;
        PH_W1: ph = PH_W2;
        PH_W2: begin
          shifter = {shifter[6:0], 1'b0};
          bits_done = bits_done + 4'd1;
          if (bits_done >= 4'd8) begin
            bits_done = '0;
            ph = PH_W3;
          end else ph = PH_W1;
        end
        PH_W3: ph = PH_W4;
        PH_R1: begin
          shifter = {shifter[6:0], sda};
          ph = PH_R2;
        end
        PH_R2: begin
          bits_done = bits_done + 4'd1;
          if (bits_done >= 4'd8) begin
            bits_done = '0;
            rx_byte = shifter;
            ph = PH_R3;
          end else ph = PH_R1;
        end
        PH_R3: ph = PH_R4;
        PH_P1: ph = PH_P2;
        PH_P2: begin
          ph = PH_IDLE;
          step_idx = '0;
          return 1'b1;
        end
        PH_S3, PH_W4, PH_R4: begin
          step_idx = step_idx + 3'd1;
          open_step();
        end
        default: ph = PH_IDLE;
      endcase
      return 1'b0;
    endfunction

    // Run one accepted tick and queue the line levels it must produce
    function void take_tick(logic [1:0] cmd, logic [7:0] regnum, logic [7:0] val,
                            logic sda);
      logic [7:0] len;
      logic       done;
      result_t    lv;
      done = 1'b0;
      if (ph == PH_IDLE && (cmd == CMD_WRITE || cmd == CMD_READ)) begin
        keep_reg = regnum;
        keep_val = val;
        rd = (cmd == CMD_READ);
        step_idx = '0;
        bits_done = '0;
        dly = '0;
        open_step();
      end
      if (ph != PH_IDLE) begin
        case (ph)
          PH_S1, PH_S2, PH_W1, PH_W2, PH_W3, PH_R1, PH_R2, PH_R3, PH_P1: len = half_ticks;
          default: len = 8'd1;
        endcase
        if (len == 8'd0) len = 8'd1;
        // drive the line latches for the current phase
        case (ph)
          PH_S1: begin drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1; end
          PH_S2: sda_q = 1'b0;
          PH_S3: scl_q = 1'b0;
          PH_W1: begin sda_q = shifter[7]; scl_q = 1'b1; end
          PH_W2: scl_q = 1'b0;
          PH_W3: begin drv_q = 1'b0; scl_q = 1'b1; end
          PH_W4: begin scl_q = 1'b0; drv_q = 1'b1; end
          PH_R1: begin drv_q = 1'b0; scl_q = 1'b1; end
          PH_R2: scl_q = 1'b0;
          PH_R3: begin drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1; end
          PH_R4: scl_q = 1'b0;
          PH_P1: begin sda_q = 1'b0; scl_q = 1'b1; end
          PH_P2: sda_q = 1'b1;
          default: ;
        endcase
        dly = dly + 8'd1;
        if (dly >= len || dly == 8'd0) begin
          dly = '0;
          done = close_phase(sda);
        end
      end
      lv.scl_level  = scl_q;
      lv.sda_level  = sda_q;
      lv.sda_drive  = drv_q;
      lv.busy_res   = (ph != PH_IDLE);
      lv.done_res   = done;
      lv.read_value = rx_byte;
      pending_levels.push_back(lv);
    endfunction

    function void diff(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("%s differs at %0t: expected %0h, got %0h", name, $time, want, got);
      end
    endfunction

    // Compare one delivered result item with the oldest queued levels
    function void check_levels(result_t got);
      result_t want;
      if (pending_levels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result item with nothing queued at %0t", $time);
        return;
      end
      want = pending_levels.pop_front();
      diff("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      diff("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      diff("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
      diff("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      diff("done_res", 8'(want.done_res), 8'(got.done_res));
      diff("read_value", want.read_value, got.read_value);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    sender_calm;
  int                    sent;
  bus_level_board        board;

  i2cm_cmd_if req_ch ();
  i2cm_res_if rsp_ch ();

  i2c_register_access_master u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic sda_for(int mode);
    if (mode == SDA_HIGH) return 1'b1;
    if (mode == SDA_LOW) return 1'b0;
    return 1'($urandom);
  endfunction

  // Result side: stall at random, with calm stretches in between
  initial begin
    int  stall;
    int  stretch;
    bit  calm;
    stall = 0;
    stretch = 0;
    calm = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        stretch = $urandom_range(100, 400);
        calm = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        stall--;
      end else begin
        rsp_ch.ready = 1'b1;
        stall = pick_gap(calm);
      end
    end
  end

  // Check every delivered result item
  always @(posedge clk) begin
    result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.scl_level  = rsp_ch.scl_level;
      got.sda_level  = rsp_ch.sda_level;
      got.sda_drive  = rsp_ch.sda_drive;
      got.busy_res   = rsp_ch.busy_res;
      got.done_res   = rsp_ch.done_res;
      got.read_value = rsp_ch.read_value;
      board.check_levels(got);
    end
  end

  // Present one tick and hold it until the block takes it
  task automatic send_tick(input logic [1:0] cmd, input logic [7:0] regnum,
                           input logic [7:0] val, input logic sda);
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.command = cmd;
    req_ch.register_address = regnum;
    req_ch.write_value = val;
    req_ch.sda_in = sda;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.take_tick(cmd, regnum, val, sda);
    sent++;
  endtask

  task automatic idle_gap();
    repeat (pick_gap(sender_calm)) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
  endtask

  // Keep ticking until the transaction in progress has finished
  task automatic ride_out(input int sda_mode, input bit noisy);
    logic [1:0] c;
    while (board.ph != PH_IDLE) begin
      idle_gap();
      c = noisy ? 2'($urandom_range(0, 3)) : CMD_IDLE;
      send_tick(c, 8'($urandom), 8'($urandom), sda_for(sda_mode));
    end
  endtask

  task automatic run_transfer(input logic [1:0] cmd, input logic [7:0] regnum,
                              input logic [7:0] val, input int sda_mode, input bit noisy);
    send_tick(cmd, regnum, val, sda_for(sda_mode));
    ride_out(sda_mode, noisy);
  endtask

  // Drop valid and wait until every queued result item has come back
  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (board.pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    settle();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    board.write_reg(idx, data);
  endtask

  initial begin
    #20_000_000;
    $display("i2c_register_access_master: mismatch");
    $finish;
  end

  initial begin
    logic [1:0] c;
    board = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_IDLE;
    req_ch.register_address = '0;
    req_ch.write_value = '0;
    req_ch.sda_in = 1'b0;
    sender_calm = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: write extremes, then a read of all ones
    run_transfer(CMD_WRITE, 8'h00, 8'hFF, SDA_HIGH, 1'b0);
    run_transfer(CMD_READ, 8'hFF, 8'h00, SDA_HIGH, 1'b0);
    // spare code and plain idle ticks leave the lines alone
    send_tick(CMD_SPARE, 8'hFF, 8'hFF, 1'b1);
    send_tick(CMD_IDLE, 8'h00, 8'h00, 1'b0);

    // Lowest address, zero half period behaves as one tick
    write_cfg(REG_DEVICE_ADDRESS, 8'h00);
    write_cfg(REG_HALF_PERIOD, 8'h00);
    run_transfer(CMD_WRITE, 8'hA5, 8'h3C, SDA_RAND, 1'b1);
    // commands arriving mid-transfer must be ignored; read of all zeros
    run_transfer(CMD_READ, 8'h5A, 8'hA5, SDA_LOW, 1'b1);
    run_transfer(CMD_READ, 8'h3C, 8'h00, SDA_RAND, 1'b0);

    // Highest address with the unused data bit set, shortest real half period
    write_cfg(REG_DEVICE_ADDRESS, 8'hFF);
    write_cfg(REG_HALF_PERIOD, 8'h01);
    run_transfer(CMD_READ, 8'h81, 8'h7E, SDA_RAND, 1'b1);

    // Longest half period through the first phase, then a shorter one
    // mid-transfer cuts the running phase short
    write_cfg(REG_HALF_PERIOD, 8'hFF);
    send_tick(CMD_WRITE, 8'h7E, 8'h81, 1'b0);
    repeat (259) begin
      idle_gap();
      send_tick(CMD_IDLE, 8'h00, 8'h00, 1'b0);
    end
    write_cfg(REG_HALF_PERIOD, 8'h01);
    ride_out(SDA_RAND, 1'b0);

    // Random phases, each with its own settings
    while (sent < 1650) begin
      write_cfg(REG_DEVICE_ADDRESS, 8'($urandom));
      write_cfg(REG_HALF_PERIOD, ($urandom_range(0, 9) == 0) ?
                8'($urandom_range(0, 8)) : 8'($urandom_range(1, 3)));
      sender_calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(60, 160)) begin
        idle_gap();
        if (board.ph == PH_IDLE) begin
          if ($urandom_range(0, 9) < 7) c = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
          else c = $urandom_range(0, 1) ? CMD_IDLE : CMD_SPARE;
        end else begin
          c = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : CMD_IDLE;
        end
        send_tick(c, 8'($urandom), 8'($urandom), 1'($urandom));
        // hold the sender until the result side has caught up
        if ($urandom_range(0, 249) == 0) settle();
      end
      ride_out(SDA_RAND, 1'b0);
    end

    settle();
    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.pending_levels.size() == 0) begin
      $display("i2c_register_access_master: match");
    end else begin
      $display("i2c_register_access_master: mismatch");
    end
    $finish;
  end

endmodule
